// File: src/bcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Codes and reset values for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int unsigned TimeWidth = 32;
	localparam int unsigned CfgWidth  = 16;

	localparam logic [CfgWidth-1:0] LongPressReset = 16'd500;
	localparam logic [CfgWidth-1:0] DoubleWinReset = 16'd300;

	typedef enum logic [1:0] {
		REQ_PRESS   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_FLUSH   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		TRIG_NONE   = 2'd0,
		TRIG_SINGLE = 2'd1,
		TRIG_DOUBLE = 2'd2,
		TRIG_LONG   = 2'd3
	} trig_t;

	typedef enum logic {
		CFG_LONG_PRESS = 1'b0,
		CFG_DOUBLE_WIN = 1'b1
	} cfg_idx_t;

endpackage
`default_nettype wire

// File: src/button_click_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Single, double and long press classifier for one button.
//
// Input channel: in_valid / in_stall carries one event word (req_type, now_ms).
// Output channel: out_valid / out_stall carries one trigger word per event,
// in event order (none, single, double, long).
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (0 long press time, 1 double click window); write only while idle.
// The input register holds an accepted event; its trigger is computed from
// it and loaded into the result register once that register can take it.
// Throughput: one event per cycle while the input is not stalled; the input
// register and the result register hold one word each, so a new event is
// taken while a result waits. A stalled receiver holds the result; once both
// registers are full the input is stalled until out_stall drops.
// Reset clears the classifier state, empties both registers and loads
// 500 ms and 300 ms into the configuration registers.
// ----------------------------------------------------------------------------
module button_click_classifier_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       trigger,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [bcc_pkg::CfgWidth-1:0]  long_press_q;
	logic [bcc_pkg::CfgWidth-1:0]  double_win_q;

	logic                          held_q;
	logic [bcc_pkg::TimeWidth-1:0] press_time_q;
	logic                          single_q;
	logic [bcc_pkg::TimeWidth-1:0] release_time_q;

	logic                          valid_s1;
	logic [1:0]                    req_s1;
	logic [bcc_pkg::TimeWidth-1:0] now_s1;

	logic                          out_valid_q;
	bcc_pkg::trig_t                trigger_q;

	logic                          adv;
	logic [bcc_pkg::TimeWidth-1:0] hold_ms;
	logic [bcc_pkg::TimeWidth-1:0] gap_ms;
	logic                          long_hit;
	logic                          in_win;
	bcc_pkg::trig_t                trig_d;
	logic                          held_d;
	logic                          press_ld;
	logic                          single_d;
	logic                          rel_ld;
	logic                          rel_clr;

	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	assign hold_ms  = now_s1 - press_time_q;
	assign gap_ms   = now_s1 - release_time_q;
	assign long_hit = hold_ms >= {{(bcc_pkg::TimeWidth-bcc_pkg::CfgWidth){1'b0}}, long_press_q};
	assign in_win   = gap_ms <= {{(bcc_pkg::TimeWidth-bcc_pkg::CfgWidth){1'b0}}, double_win_q};

	always_comb begin
		trig_d   = bcc_pkg::TRIG_NONE;
		held_d   = held_q;
		press_ld = 1'b0;
		single_d = single_q;
		rel_ld   = 1'b0;
		rel_clr  = 1'b0;
		unique case (req_s1)
			bcc_pkg::REQ_PRESS: begin
				if (!held_q) begin
					held_d   = 1'b1;
					press_ld = 1'b1;
				end
			end
			bcc_pkg::REQ_RELEASE: begin
				if (held_q) begin
					held_d = 1'b0;
					if (long_hit) begin
						trig_d   = bcc_pkg::TRIG_LONG;
						single_d = 1'b0;
						rel_clr  = 1'b1;
					end else if (single_q && in_win) begin
						trig_d   = bcc_pkg::TRIG_DOUBLE;
						single_d = 1'b0;
						rel_clr  = 1'b1;
					end else begin
						single_d = 1'b1;
						rel_ld   = 1'b1;
					end
				end
			end
			bcc_pkg::REQ_FLUSH: begin
				if (single_q && !in_win) begin
					trig_d   = bcc_pkg::TRIG_SINGLE;
					single_d = 1'b0;
					rel_clr  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= bcc_pkg::LongPressReset;
			double_win_q <= bcc_pkg::DoubleWinReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcc_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data;
				bcc_pkg::CFG_DOUBLE_WIN: double_win_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= req_type;
			now_s1 <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= 1'b0;
			press_time_q   <= '0;
			single_q       <= 1'b0;
			release_time_q <= '0;
		end else if (adv) begin
			held_q   <= held_d;
			single_q <= single_d;
			if (press_ld) begin
				press_time_q <= now_s1;
			end
			if (rel_ld) begin
				release_time_q <= now_s1;
			end else if (rel_clr) begin
				release_time_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trigger_q <= trig_d;
		end
	end

	assign out_valid = out_valid_q;
	assign trigger   = trigger_q;

	// hold the word in the input stage only when the result stage is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a full pipeline");

	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1 == bcc_pkg::REQ_PRESS) |=> held_q)
		else $error("press did not set held");

	a_long_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && trig_d == bcc_pkg::TRIG_LONG)
		|=> (!single_q && release_time_q == '0 && !held_q))
		else $error("long press left state behind");

	a_single_src: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && trig_d == bcc_pkg::TRIG_SINGLE) |-> (single_q && req_s1 == bcc_pkg::REQ_FLUSH))
		else $error("single issued without a pending click");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_valid_q && trigger_q == $past(trig_d)))
		else $error("result register missed a word");

endmodule
`default_nettype wire

// File: bench/button_click_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_unit_test
// Self-checking bench for the button click classifier. A driver feeds event
// words from a queue, an in-bench classifier predicts each trigger at the
// accepting edge, and a monitor checks every trigger word in order. Directed
// gestures at reset settings are followed by random gesture streams under
// several threshold settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module button_click_classifier_unit_test;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned RxHoldCycles = 80;

	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] t;
	} btn_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type = bcc_pkg::REQ_PRESS;
	logic [31:0]       now_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        trigger;
	logic              cfg_we = 1'b0;
	bcc_pkg::cfg_idx_t cfg_index = bcc_pkg::CFG_LONG_PRESS;
	logic [15:0]       cfg_data = '0;

	// classifier prediction state
	logic        btn_down = 1'b0;
	logic [31:0] down_at = '0;
	logic        click_open = 1'b0;
	logic [31:0] up_at = '0;
	logic [31:0] long_ms = 32'(bcc_pkg::LongPressReset);
	logic [31:0] window_ms = 32'(bcc_pkg::DoubleWinReset);

	btn_event_t      event_q[$];
	bcc_pkg::trig_t  trig_q[$];
	btn_event_t      next_ev;
	bcc_pkg::trig_t  want;
	logic [31:0]     stamp = '0;

	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_errors = 0;
	int unsigned cycle_count = 0;
	int unsigned idle_tx = 18;
	int unsigned idle_rx = 18;
	int unsigned holds_asked = 0;
	int unsigned holds_done = 0;
	int unsigned rx_hold = 0;

	button_click_classifier_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.trigger   (trigger),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bcc_pkg::trig_t classify(logic [1:0] req, logic [31:0] t);
		bcc_pkg::trig_t r;
		r = bcc_pkg::TRIG_NONE;
		case (req)
			bcc_pkg::REQ_PRESS: begin
				if (!btn_down) begin
					btn_down = 1'b1;
					down_at = t;
				end
			end
			bcc_pkg::REQ_RELEASE: begin
				if (btn_down) begin
					btn_down = 1'b0;
					if (32'(t - down_at) >= long_ms) begin
						click_open = 1'b0;
						up_at = '0;
						r = bcc_pkg::TRIG_LONG;
					end else if (click_open && 32'(t - up_at) <= window_ms) begin
						click_open = 1'b0;
						up_at = '0;
						r = bcc_pkg::TRIG_DOUBLE;
					end else begin
						click_open = 1'b1;
						up_at = t;
					end
				end
			end
			bcc_pkg::REQ_FLUSH: begin
				if (click_open && 32'(t - up_at) > window_ms) begin
					click_open = 1'b0;
					up_at = '0;
					r = bcc_pkg::TRIG_SINGLE;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] gap(logic [31:0] th);
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, th);
			6, 7:             return th - 1 + $urandom_range(0, 2);
			8, 9, 10:         return th + $urandom_range(1, 3000);
			11, 12, 13:       return $urandom_range(0, 20);
			14:               return $urandom_range(0, th / 2);
			default:          return $urandom();
		endcase
	endfunction

	task automatic push_event(logic [1:0] req, logic [31:0] t);
		event_q.push_back('{req: req, t: t});
		n_queued++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (n_accepted != n_queued || trig_q.size() != 0);
	endtask

	task automatic apply_settings(logic [15:0] lp, logic [15:0] dw);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bcc_pkg::CFG_LONG_PRESS;
		cfg_data <= lp;
		@(posedge clk);
		cfg_index <= bcc_pkg::CFG_DOUBLE_WIN;
		cfg_data <= dw;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_ms = 32'(lp);
		window_ms = 32'(dw);
	endtask

	task automatic add_gestures(int unsigned count);
		int unsigned n;
		n = 0;
		while (n < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					push_event(bcc_pkg::REQ_PRESS, stamp);
					stamp += gap(long_ms);
					push_event(bcc_pkg::REQ_RELEASE, stamp);
					n += 2;
				end
				3, 4: begin
					push_event(bcc_pkg::REQ_PRESS, stamp);
					stamp += gap(long_ms);
					push_event(bcc_pkg::REQ_RELEASE, stamp);
					stamp += gap(window_ms);
					push_event(bcc_pkg::REQ_PRESS, stamp);
					stamp += gap(long_ms);
					push_event(bcc_pkg::REQ_RELEASE, stamp);
					n += 4;
				end
				5: begin
					push_event(bcc_pkg::REQ_PRESS, stamp);
					stamp += long_ms - 1 + $urandom_range(0, 3);
					push_event(bcc_pkg::REQ_RELEASE, stamp);
					n += 2;
				end
				6, 7: begin
					stamp += gap(window_ms);
					push_event(bcc_pkg::REQ_FLUSH, stamp);
					n += 1;
				end
				8: begin
					push_event(2'($urandom_range(0, 3)), $urandom());
					n += 1;
				end
				default: begin
					push_event(2'($urandom_range(0, 1)), stamp);
					stamp += $urandom_range(0, 50);
					n += 1;
				end
			endcase
			stamp += gap(window_ms);
		end
	endtask

	// drive event words
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				trig_q.push_back(classify(req_type, now_ms));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_tx) begin
					next_ev = event_q.pop_front();
					in_valid <= 1'b1;
					req_type <= next_ev.req;
					now_ms <= next_ev.t;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// hold off the receiver on request
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (holds_done != holds_asked) begin
			rx_hold <= RxHoldCycles;
			holds_done <= holds_done + 1;
		end
	end

	// check trigger words
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (trig_q.size() == 0) begin
					if (n_errors < 10)
						$display("unexpected trigger %0d at cycle %0d", trigger, cycle_count);
					n_errors++;
				end else begin
					want = trig_q.pop_front();
					if (trigger !== want) begin
						if (n_errors < 10)
							$display("trigger mismatch at cycle %0d: expected %0d, got %0d",
								cycle_count, want, trigger);
						n_errors++;
					end
				end
			end
			out_stall <= (rx_hold != 0) || ($urandom_range(0, 99) < idle_rx);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_event(bcc_pkg::REQ_PRESS, 32'd0);
		push_event(bcc_pkg::REQ_PRESS, 32'd50);
		push_event(bcc_pkg::REQ_RELEASE, 32'd100);
		push_event(bcc_pkg::REQ_PRESS, 32'd150);
		push_event(bcc_pkg::REQ_RELEASE, 32'd250);
		push_event(bcc_pkg::REQ_RELEASE, 32'd260);
		push_event(bcc_pkg::REQ_PRESS, 32'd1000);
		push_event(bcc_pkg::REQ_RELEASE, 32'd1500);
		push_event(bcc_pkg::REQ_PRESS, 32'd2000);
		push_event(bcc_pkg::REQ_RELEASE, 32'd2499);
		push_event(bcc_pkg::REQ_FLUSH, 32'd2799);
		push_event(bcc_pkg::REQ_FLUSH, 32'd2800);
		push_event(bcc_pkg::REQ_FLUSH, 32'd2900);
		push_event(REQ_UNUSED, 32'hFFFF_FFFF);
		push_event(bcc_pkg::REQ_PRESS, 32'hFFFF_FF00);
		push_event(bcc_pkg::REQ_RELEASE, 32'h0000_0010);
		push_event(bcc_pkg::REQ_FLUSH, 32'hFFFF_FFF0);
		push_event(bcc_pkg::REQ_PRESS, 32'd100);
		push_event(bcc_pkg::REQ_RELEASE, 32'd50);
		push_event(bcc_pkg::REQ_PRESS, 32'd5000);
		push_event(bcc_pkg::REQ_RELEASE, 32'd5100);
		push_event(bcc_pkg::REQ_PRESS, 32'd5200);
		push_event(bcc_pkg::REQ_RELEASE, 32'd5500);
		push_event(bcc_pkg::REQ_FLUSH, 32'd5801);
		wait_idle();

		apply_settings(16'd0, 16'd0);
		stamp = $urandom();
		add_gestures(100);
		wait_idle();

		apply_settings(16'hFFFF, 16'hFFFF);
		add_gestures(100);
		wait_idle();

		apply_settings(16'hFFFF, 16'd0);
		idle_tx = 0;
		idle_rx = 0;
		add_gestures(100);
		wait_idle();
		idle_tx = 18;
		idle_rx = 18;

		apply_settings(16'd0, 16'hFFFF);
		holds_asked++;
		add_gestures(100);
		wait_idle();

		apply_settings(bcc_pkg::LongPressReset, bcc_pkg::DoubleWinReset);
		stamp = 32'hFFFF_F000;
		add_gestures(100);
		wait_idle();

		apply_settings(16'($urandom_range(1, 1000)), 16'($urandom_range(1, 1000)));
		add_gestures(100);
		wait_idle();

		repeat (4) @(posedge clk);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
